>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_CLK(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Types and constants shared by the curtain position estimator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpe_pkg;

  localparam int POS_W    = 7;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int IDX_IN_W = 3;
  localparam int FUNC_W   = 2;
  localparam int ARG_W    = 16;
  localparam int PROD_W   = 23;
  localparam int RECIP_W  = 24;
  localparam int MULP_W   = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 30;
  localparam int DIV_CNT_W   = 5;

  localparam logic [POS_W-1:0]     FULL_SCALE        = 7'd100;
  localparam logic [RECIP_W-1:0]   RECIP_100         = 24'd10737419;
  localparam logic [MS_W-1:0]      FULL_TRAVEL_RESET = 16'd10000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS         = 5'd23;

  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MAG,
    ST_DUR,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN_MUL,
    ST_FINISH,
    ST_RESULT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAG_F,
    MUL_DUR,
    MUL_EL_MAG,
    MUL_DIST_F,
    MUL_REM
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     setup;
    mul_sel_t mul;
    logic     check;
    logic     div_start;
    logic     finish;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_valid;
    logic func_set;
    logic flat;
    logic past_end;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

>>> hw/rtl/curtain_position_estimator.sv
// One item at a time: a transfer is taken only once the previous result is loaded
// into the output register. A bad index goes straight to the result, a held curtain
// or a set skips the estimate, and a curtain past its segment end skips the 23-step
// serial divider, which sets the long path. A finished result waits in the output
// register while the next item is taken. Reset: synchronous, active high; all
// segments go to position 0 at time 0, full_travel_ms to 10000, output channel empty.
// ----------------------------------------------------------------------------
// curtain_position_estimator
// Time-interpolated position estimate for a set of curtains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module curtain_position_estimator #(
  parameter int CURTAINS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,       // full_travel_ms
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // curtain_index[2:0], position_arg[18:3], now_ms[50:19]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // current_position[6:0], target_position[13:7],
                                      // remaining_ms[29:14]
  output logic        m_axis_tuser    // index_valid
);

  cpe_pkg::dp_cmd_t    cmd;
  cpe_pkg::dp_status_t status;

  cpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cpe_datapath #(
    .CURTAINS (CURTAINS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .func          (s_axis_tuser),
    .curtain_index (s_axis_tdata[2:0]),
    .position_arg  (s_axis_tdata[18:3]),
    .now_ms        (s_axis_tdata[50:19]),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> hw/rtl/cpe_div.sv
// ----------------------------------------------------------------------------
// cpe_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpe_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cpe_pkg::PROD_W-1:0] dividend,
  input  logic [cpe_pkg::MS_W-1:0]   divisor,
  output logic                       busy,
  output logic                       done,
  output logic [cpe_pkg::POS_W-1:0]  quotient
);

  logic [cpe_pkg::DIV_CNT_W-1:0] cnt;
  logic [cpe_pkg::PROD_W-1:0]    quo;
  logic [cpe_pkg::MS_W-1:0]      rem;
  logic [cpe_pkg::MS_W-1:0]      dsr;
  logic [cpe_pkg::MS_W:0]        shifted;
  logic [cpe_pkg::MS_W:0]        sub;
  logic                          ge;

  always_comb begin
    shifted = {rem, quo[cpe_pkg::PROD_W-1]};
    ge      = shifted >= {1'b0, dsr};
    sub     = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cpe_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cpe_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? sub[cpe_pkg::MS_W-1:0] : shifted[cpe_pkg::MS_W-1:0];
      quo <= {quo[cpe_pkg::PROD_W-2:0], ge};
    end
  end

  // quotient is below the distance, so the low bits carry all of it
  assign quotient = quo[cpe_pkg::POS_W-1:0];

  `ASSERT_CLK(a_start_idle, clk, rst, !(start && busy))
  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy && !done)

endmodule

>>> hw/rtl/cpe_datapath.sv
// ----------------------------------------------------------------------------
// cpe_datapath
// Segment store, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpe_datapath #(
  parameter int CURTAINS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cpe_pkg::dp_cmd_t             cmd,
  output cpe_pkg::dp_status_t          status,
  input  logic                         cfg_we,
  input  logic [cpe_pkg::MS_W-1:0]     cfg_data,
  input  logic [cpe_pkg::FUNC_W-1:0]   func,
  input  logic [cpe_pkg::IDX_IN_W-1:0] curtain_index,
  input  logic [cpe_pkg::ARG_W-1:0]    position_arg,
  input  logic [cpe_pkg::TIME_W-1:0]   now_ms,
  input  logic                         m_axis_tready,
  output logic                         m_axis_tvalid,
  output logic [31:0]                  m_axis_tdata,
  output logic                         m_axis_tuser
);

  localparam int IDX_W = (CURTAINS > 1) ? $clog2(CURTAINS) : 1;

  logic [cpe_pkg::POS_W-1:0]  seg_start  [CURTAINS];
  logic [cpe_pkg::POS_W-1:0]  seg_target [CURTAINS];
  logic [cpe_pkg::TIME_W-1:0] seg_time   [CURTAINS];
  logic [cpe_pkg::MS_W-1:0]   full_travel_ms;

  logic                         in_valid;
  logic [IDX_W-1:0]             rd_idx;
  logic [cpe_pkg::POS_W-1:0]    arg_clamp;

  logic                         idx_valid;
  logic                         func_move;
  logic                         func_set;
  logic [IDX_W-1:0]             idx;
  logic [cpe_pkg::TIME_W-1:0]   now;
  logic [cpe_pkg::POS_W-1:0]    s_pos;
  logic [cpe_pkg::POS_W-1:0]    t_pos;
  logic [cpe_pkg::TIME_W-1:0]   t_start;
  logic [cpe_pkg::POS_W-1:0]    tt;
  logic [cpe_pkg::POS_W-1:0]    pos;
  logic [cpe_pkg::POS_W-1:0]    mag;
  logic [cpe_pkg::TIME_W-1:0]   el;
  logic [cpe_pkg::PROD_W-1:0]   prod;
  logic [cpe_pkg::MS_W-1:0]     dur;
  logic [cpe_pkg::MS_W-1:0]     rem_ms;
  logic [cpe_pkg::POS_W-1:0]    cur;
  logic [cpe_pkg::POS_W-1:0]    gap;

  logic [cpe_pkg::PROD_W-1:0]   mul_a;
  logic [cpe_pkg::RECIP_W-1:0]  mul_b;
  logic [cpe_pkg::MULP_W-1:0]   mul_p;
  logic [cpe_pkg::MS_W-1:0]     recip_q;

  logic                         div_busy;
  logic                         div_done;
  logic [cpe_pkg::POS_W-1:0]    div_q;

  always_comb begin
    in_valid  = {1'b0, curtain_index} < (cpe_pkg::IDX_IN_W + 1)'(CURTAINS);
    rd_idx    = in_valid ? curtain_index[IDX_W-1:0] : '0;
    arg_clamp = (position_arg > cpe_pkg::ARG_W'(cpe_pkg::FULL_SCALE))
                ? cpe_pkg::FULL_SCALE : position_arg[cpe_pkg::POS_W-1:0];
    gap       = (tt > pos) ? (tt - pos) : (pos - tt);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      cpe_pkg::MUL_MAG_F: begin
        mul_a = cpe_pkg::PROD_W'(full_travel_ms);
        mul_b = cpe_pkg::RECIP_W'(mag);
      end
      cpe_pkg::MUL_DUR, cpe_pkg::MUL_REM: begin
        mul_a = prod;
        mul_b = cpe_pkg::RECIP_100;
      end
      cpe_pkg::MUL_EL_MAG: begin
        mul_a = cpe_pkg::PROD_W'(el[cpe_pkg::MS_W-1:0]);
        mul_b = cpe_pkg::RECIP_W'(mag);
      end
      cpe_pkg::MUL_DIST_F: begin
        mul_a = cpe_pkg::PROD_W'(full_travel_ms);
        mul_b = cpe_pkg::RECIP_W'(gap);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = cpe_pkg::MULP_W'(mul_a) * cpe_pkg::MULP_W'(mul_b);
    recip_q = mul_p[cpe_pkg::RECIP_SHIFT +: cpe_pkg::MS_W];
  end

  cpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (dur),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // config register, segment store and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      full_travel_ms <= cpe_pkg::FULL_TRAVEL_RESET;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < CURTAINS; i++) begin
        seg_start[i]  <= '0;
        seg_target[i] <= '0;
        seg_time[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        full_travel_ms <= cfg_data;
      end
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.finish && idx_valid && (func_move || func_set)) begin
        seg_start[idx]  <= pos;
        seg_target[idx] <= tt;
        seg_time[idx]   <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_valid <= in_valid;
      func_move <= (func == cpe_pkg::FUNC_MOVE);
      func_set  <= (func == cpe_pkg::FUNC_SET);
      idx       <= rd_idx;
      now       <= now_ms;
      s_pos     <= seg_start[rd_idx];
      t_pos     <= seg_target[rd_idx];
      t_start   <= seg_time[rd_idx];
      tt        <= (func == cpe_pkg::FUNC_MOVE || func == cpe_pkg::FUNC_SET)
                   ? arg_clamp : seg_target[rd_idx];
      pos       <= (func == cpe_pkg::FUNC_SET) ? arg_clamp : seg_target[rd_idx];
    end
    if (cmd.setup) begin
      mag <= (t_pos > s_pos) ? (t_pos - s_pos) : (s_pos - t_pos);
      el  <= now - t_start;
    end
    case (cmd.mul)
      cpe_pkg::MUL_MAG_F, cpe_pkg::MUL_EL_MAG, cpe_pkg::MUL_DIST_F: begin
        prod <= mul_p[cpe_pkg::PROD_W-1:0];
      end
      cpe_pkg::MUL_DUR: begin
        dur <= recip_q;
      end
      cpe_pkg::MUL_REM: begin
        rem_ms <= recip_q;
      end
      default: begin
      end
    endcase
    if (cmd.check && status.past_end) begin
      pos <= t_pos;
    end
    if (div_done) begin
      pos <= (s_pos > t_pos) ? (s_pos - div_q) : (s_pos + div_q);
    end
    if (cmd.finish) begin
      // a move too short to take a whole millisecond lands at once
      cur <= (func_move && (prod < cpe_pkg::PROD_W'(cpe_pkg::FULL_SCALE))) ? tt : pos;
    end
    if (cmd.out_load) begin
      m_axis_tdata <= idx_valid ? {2'b00, rem_ms, tt, cur} : '0;
      m_axis_tuser <= idx_valid;
    end
  end

  always_comb begin
    status.idx_valid = idx_valid;
    status.func_set  = func_set;
    status.flat      = (s_pos == t_pos);
    status.past_end  = el >= cpe_pkg::TIME_W'(dur);
    status.div_done  = div_done;
    status.out_busy  = m_axis_tvalid && !m_axis_tready;
  end

  `ASSERT_CLK(a_div_nonzero, clk, rst, !cmd.div_start || (dur != '0))
  `ASSERT_CLK(a_div_quiet, clk, rst, !(div_busy && cmd.finish))
  `ASSERT_CLK(a_out_range, clk, rst,
    !m_axis_tvalid || (m_axis_tdata[6:0] <= 7'd100 && m_axis_tdata[13:7] <= 7'd100))

endmodule

>>> hw/rtl/cpe_ctrl.sv
// ----------------------------------------------------------------------------
// cpe_ctrl
// Sequencer for one item: estimate, update segment, compute result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpe_pkg::dp_status_t status,
  output cpe_pkg::dp_cmd_t    cmd
);

  cpe_pkg::ctrl_state_t state;
  cpe_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpe_pkg::ST_IDLE: begin
        if (in_valid) state_next = cpe_pkg::ST_DECIDE;
      end
      cpe_pkg::ST_DECIDE: begin
        if (!status.idx_valid) begin
          state_next = cpe_pkg::ST_RESULT;
        end else if (status.func_set || status.flat) begin
          state_next = cpe_pkg::ST_FIN_MUL;
        end else begin
          state_next = cpe_pkg::ST_MAG;
        end
      end
      cpe_pkg::ST_MAG:       state_next = cpe_pkg::ST_DUR;
      cpe_pkg::ST_DUR:       state_next = cpe_pkg::ST_CHECK;
      cpe_pkg::ST_CHECK: begin
        state_next = status.past_end ? cpe_pkg::ST_FIN_MUL : cpe_pkg::ST_DIV_START;
      end
      cpe_pkg::ST_DIV_START: state_next = cpe_pkg::ST_DIV_WAIT;
      cpe_pkg::ST_DIV_WAIT: begin
        if (status.div_done) state_next = cpe_pkg::ST_FIN_MUL;
      end
      cpe_pkg::ST_FIN_MUL:   state_next = cpe_pkg::ST_FINISH;
      cpe_pkg::ST_FINISH:    state_next = cpe_pkg::ST_RESULT;
      cpe_pkg::ST_RESULT: begin
        if (!status.out_busy) state_next = cpe_pkg::ST_IDLE;
      end
      default:               state_next = cpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.setup     = 1'b0;
    cmd.mul       = cpe_pkg::MUL_NONE;
    cmd.check     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.finish    = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      cpe_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      cpe_pkg::ST_DECIDE:    cmd.setup = 1'b1;
      cpe_pkg::ST_MAG:       cmd.mul = cpe_pkg::MUL_MAG_F;
      cpe_pkg::ST_DUR:       cmd.mul = cpe_pkg::MUL_DUR;
      cpe_pkg::ST_CHECK: begin
        cmd.mul   = cpe_pkg::MUL_EL_MAG;
        cmd.check = 1'b1;
      end
      cpe_pkg::ST_DIV_START: cmd.div_start = 1'b1;
      cpe_pkg::ST_FIN_MUL:   cmd.mul = cpe_pkg::MUL_DIST_F;
      cpe_pkg::ST_FINISH: begin
        cmd.mul    = cpe_pkg::MUL_REM;
        cmd.finish = 1'b1;
      end
      cpe_pkg::ST_RESULT:    cmd.out_load = !status.out_busy;
      default: begin
      end
    endcase
  end

endmodule
